@@ hdl/kst_pkg.sv @@
`timescale 1ns / 1ps

package kst_pkg;

  localparam int ENTRIES   = 16;
  localparam int KEY_WIDTH = 32;
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_WRONG = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [KEY_WIDTH-1:0] wr_data;
  } ram_req_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] status;
  } res_t;

endpackage

@@ hdl/kst_key_ram.sv @@
`timescale 1ns / 1ps

module kst_key_ram (
  input  logic                          clk,
  input  kst_pkg::ram_req_t             req,
  output logic [kst_pkg::KEY_WIDTH-1:0] rd_data
);

  logic [kst_pkg::KEY_WIDTH-1:0] mem [kst_pkg::ENTRIES];
  logic [kst_pkg::KEY_WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/kst_ctrl.sv @@
`timescale 1ns / 1ps

module kst_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic [1:0]                    req_op,
  input  logic [31:0]                   req_key,
  output kst_pkg::ram_req_t             ram_req,
  input  logic [kst_pkg::KEY_WIDTH-1:0] ram_q,
  output kst_pkg::res_t                 res,
  input  logic                          res_ready
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESULT
  } state_t;

  localparam int KW = kst_pkg::KEY_WIDTH;
  localparam int IW = kst_pkg::IDX_W;

  state_t                   state_r, state_nxt;
  logic [1:0]               op_r, op_nxt;
  logic [KW-1:0]            key_r, key_nxt;
  logic [1:0]               status_r, status_nxt;
  logic [IW-1:0]            idx_r, idx_nxt;
  logic [IW-1:0]            cmp_idx_r, cmp_idx_nxt;
  logic [IW-1:0]            free_idx_r, free_idx_nxt;
  logic                     issue_r, issue_nxt;
  logic                     pend_r, pend_nxt;
  logic                     free_found_r, free_found_nxt;
  logic [kst_pkg::ENTRIES-1:0] valid_r, valid_nxt;

  logic [KW+31:0]           key_ext;
  logic [KW-1:0]            key_in;
  logic                     match;
  logic                     last_cmp;

  // Keys wider than the port are zero extended, narrower ones truncated.
  assign key_ext = {KW'(0), req_key};
  assign key_in  = key_ext[KW-1:0];

  assign match    = pend_r && valid_r[cmp_idx_r] && (ram_q == key_r);
  assign last_cmp = pend_r && (cmp_idx_r == kst_pkg::LAST_IDX);

  assign req_ready    = (state_r == S_IDLE);
  assign res.valid    = (state_r == S_RESULT);
  assign res.status   = status_r;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    status_nxt     = status_r;
    idx_nxt        = idx_r;
    cmp_idx_nxt    = cmp_idx_r;
    free_idx_nxt   = free_idx_r;
    issue_nxt      = issue_r;
    pend_nxt       = pend_r;
    free_found_nxt = free_found_r;
    valid_nxt      = valid_r;

    ram_req.rd_en   = 1'b0;
    ram_req.rd_addr = idx_r;
    ram_req.wr_en   = 1'b0;
    ram_req.wr_addr = free_idx_r;
    ram_req.wr_data = key_r;

    unique case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          op_nxt         = req_op;
          key_nxt        = key_in;
          idx_nxt        = '0;
          issue_nxt      = 1'b1;
          pend_nxt       = 1'b0;
          free_found_nxt = 1'b0;
          if ((key_in == '0) ||
              !((req_op == kst_pkg::OP_INSERT) || (req_op == kst_pkg::OP_QUERY) ||
                (req_op == kst_pkg::OP_REMOVE))) begin
            status_nxt = kst_pkg::ST_WRONG;
            state_nxt  = S_RESULT;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Reads are issued one entry ahead of the compare.
        ram_req.rd_en = issue_r;
        pend_nxt      = issue_r;
        if (issue_r) begin
          cmp_idx_nxt = idx_r;
          if (!free_found_r && !valid_r[idx_r]) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = idx_r;
          end
          if (idx_r == kst_pkg::LAST_IDX) begin
            issue_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r + IW'(1);
          end
        end

        if (match) begin
          if (op_r == kst_pkg::OP_REMOVE) begin
            valid_nxt[cmp_idx_r] = 1'b0;
          end
          status_nxt = kst_pkg::ST_OK;
          state_nxt  = S_RESULT;
        end else if (last_cmp) begin
          if (op_r == kst_pkg::OP_INSERT) begin
            if (free_found_r) begin
              ram_req.wr_en        = 1'b1;
              valid_nxt[free_idx_r] = 1'b1;
              status_nxt           = kst_pkg::ST_OK;
            end else begin
              status_nxt = kst_pkg::ST_FULL;
            end
          end else begin
            status_nxt = kst_pkg::ST_WRONG;
          end
          state_nxt = S_RESULT;
        end
      end

      S_RESULT: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      issue_r <= 1'b0;
      pend_r  <= 1'b0;
      valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      issue_r <= issue_nxt;
      pend_r  <= pend_nxt;
      valid_r <= valid_nxt;
    end
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    status_r     <= status_nxt;
    idx_r        <= idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    free_idx_r   <= free_idx_nxt;
    free_found_r <= free_found_nxt;
  end

endmodule

@@ hdl/key_set_table_top.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// in_       slave      in_tvalid/in_tready   in_tuser: opcode; in_tdata: key
// out_      master     out_tvalid/out_tready out_tdata: status
//
// A lookup walks the key memory one entry per cycle through its single read
// port; a hit ends the walk early, and a zero key or unused opcode skips the
// walk and goes straight to the result.
// Reset clears the valid flags at once; key memory contents need no clearing.
// The result waits in an output register, so a stalled out_tready holds
// back the next item only when that register is still full.

module key_set_table_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] key
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [1:0] status, [7:2] zero
);

  kst_pkg::ram_req_t             ram_req;
  logic [kst_pkg::KEY_WIDTH-1:0] ram_q;
  kst_pkg::res_t                 res;
  logic                          res_ready;
  logic                          out_valid_r;
  logic [1:0]                    out_status_r;

  kst_key_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_q)
  );

  kst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req_op    (in_tuser),
    .req_key   (in_tdata),
    .ram_req   (ram_req),
    .ram_q     (ram_q),
    .res       (res),
    .res_ready (res_ready)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (res.valid && res_ready) begin
      out_status_r <= res.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_status_r};

endmodule

@@ hdl/kst_checker.sv @@
`timescale 1ns / 1ps

module kst_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata
);

  // A result beat that is not taken stays and keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output beat dropped or changed while stalled");

  // Every item needs work after it is taken, so the block is busy after a beat.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted again right after a beat");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[1:0] == kst_pkg::ST_OK) ||
                    (out_tdata[1:0] == kst_pkg::ST_WRONG) ||
                    (out_tdata[1:0] == kst_pkg::ST_FULL)))
    else $error("unused status code on output");

  a_status_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:2] == 6'd0))
    else $error("padding bits of output beat not zero");

endmodule

bind key_set_table_top kst_checker u_kst_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
